/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property sampled on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Next-cycle implication sampled outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/md5_pkg.sv */
// Shared types, constants and table functions of the MD5 engine.
`default_nettype none
package md5_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PREF,
		ST_ROUND,
		ST_FOLD
	} md5_state_t;

	localparam md5_work_t IV = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_LIMIT = 6'd56;
	localparam logic [3:0] LAST_WORD = 4'd15;
	localparam logic [3:0] LEN_LO_WORD = 4'd14;
	localparam logic [1:0] LAST_INDEX = 2'd3;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Message word used by a round.
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] i4;
		logic [3:0] idx;
		i4 = rnd[3:0];
		unique case (rnd[5:4])
			2'd0: idx = i4;
			2'd1: idx = i4 * 4'd5 + 4'd1;
			2'd2: idx = i4 * 4'd3 + 4'd5;
			default: idx = i4 * 4'd7;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
		logic [4:0] s;
		unique case ({rnd[5:4], rnd[1:0]})
			4'h0: s = 5'd7;
			4'h1: s = 5'd12;
			4'h2: s = 5'd17;
			4'h3: s = 5'd22;
			4'h4: s = 5'd5;
			4'h5: s = 5'd9;
			4'h6: s = 5'd14;
			4'h7: s = 5'd20;
			4'h8: s = 5'd4;
			4'h9: s = 5'd11;
			4'ha: s = 5'd16;
			4'hb: s = 5'd23;
			4'hc: s = 5'd6;
			4'hd: s = 5'd10;
			4'he: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* design/md5_hash_engine.sv */
// A byte transaction is taken in the idle state; a full block then runs fetch, 64 rounds and fold.
// Message end: padding words go in one per cycle up to word 15; a further block follows if the length does not fit.
// The digest follows as four words, one per cycle while taken; the next message may start meanwhile.
// Throughput is set by the single round unit and the block memory port; no bytes are taken while a block runs.
// Reset: chain returns to the MD5 initial values, counters and valids clear; block memory is not cleared.
`default_nettype none
module md5_hash_engine
	import md5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        message_end,
	output logic             digest_valid,
	input  wire logic        digest_ready,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word
);

	md5_state_t state_q, state_d;

	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic [5:0]  round_q;
	logic [3:0]  pad_w_q;
	logic        pad_first_q;
	logic [1:0]  pad_lane_q;
	logic        len_blk_q;
	logic        final_q;
	logic        extra_q;
	logic        end_pend_q;
	md5_work_t   chain_q;
	logic        dvalid_q;
	logic [1:0]  idx_q;

	logic [31:0] acc_q;
	md5_work_t   work_q;
	md5_work_t   work_next;
	logic [31:0] digest_q [4];

	logic [31:0] blk_mem_q [16];
	logic [31:0] blk_rd_q;

	logic        item_acc;
	logic        fire_block;
	logic [5:0]  p_end;
	logic [31:0] new_word;
	logic [31:0] pad_word;
	logic [63:0] bit_len;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	md5_work_t   chain_sum;

	assign item_acc   = item_valid && item_ready;
	assign fire_block = byte_present && (fill_q == LAST_POS);
	assign p_end      = byte_present ? fill_q + 6'd1 : fill_q;
	assign bit_len    = {byte_cnt_q, 3'b000};

	assign chain_sum.a = chain_q.a + work_q.a;
	assign chain_sum.b = chain_q.b + work_q.b;
	assign chain_sum.c = chain_q.c + work_q.c;
	assign chain_sum.d = chain_q.d + work_q.d;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			new_word[8*j +: 8] = (2'(j) == fill_q[1:0]) ? data_byte : acc_q[8*j +: 8];
			if (2'(j) < pad_lane_q)
				pad_word[8*j +: 8] = acc_q[8*j +: 8];
			else if (2'(j) == pad_lane_q)
				pad_word[8*j +: 8] = PAD_BYTE;
			else
				pad_word[8*j +: 8] = 8'h00;
		end
	end

	md5_round u_round (
		.work      (work_q),
		.msg       (blk_rd_q),
		.rnd       (round_q),
		.work_next (work_next)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (fire_block)
						state_d = ST_PREF;
					else if (message_end)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (pad_w_q == LAST_WORD)
					state_d = ST_PREF;
			end
			ST_PREF: state_d = ST_ROUND;
			ST_ROUND: begin
				if (round_q == LAST_POS)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (final_q) begin
					if (!dvalid_q)
						state_d = ST_IDLE;
				end else if (extra_q || end_pend_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: intake, memory ports.
	always_comb begin
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = fill_q[5:2];
		mem_wdata  = new_word;
		mem_raddr  = 4'd0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				mem_we     = item_acc && byte_present && (fill_q[1:0] == LAST_INDEX);
			end
			ST_PAD: begin
				mem_we    = 1'b1;
				mem_waddr = pad_w_q;
				if (pad_first_q)
					mem_wdata = pad_word;
				else if (len_blk_q && (pad_w_q == LEN_LO_WORD))
					mem_wdata = bit_len[31:0];
				else if (len_blk_q && (pad_w_q == LAST_WORD))
					mem_wdata = bit_len[63:32];
				else
					mem_wdata = '0;
			end
			ST_ROUND: mem_raddr = msg_index(round_q + 6'd1);
			default: ;
		endcase
	end

	// Block memory; no write overlaps a compression, so reads need no forwarding.
	always_ff @(posedge clk) begin
		if (mem_we)
			blk_mem_q[mem_waddr] <= mem_wdata;
		blk_rd_q <= blk_mem_q[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_acc && byte_present)
			acc_q <= new_word;
		if (state_q == ST_PREF)
			work_q <= chain_q;
		else if (state_q == ST_ROUND)
			work_q <= work_next;
		if (state_q == ST_FOLD && final_q && !dvalid_q) begin
			digest_q[0] <= chain_sum.a;
			digest_q[1] <= chain_sum.b;
			digest_q[2] <= chain_sum.c;
			digest_q[3] <= chain_sum.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			round_q     <= '0;
			pad_w_q     <= '0;
			pad_first_q <= 1'b0;
			pad_lane_q  <= '0;
			len_blk_q   <= 1'b0;
			final_q     <= 1'b0;
			extra_q     <= 1'b0;
			end_pend_q  <= 1'b0;
			chain_q     <= IV;
			dvalid_q    <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (dvalid_q && digest_ready) begin
				if (idx_q == LAST_INDEX)
					dvalid_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (byte_present) begin
							fill_q     <= fill_q + 6'd1;
							byte_cnt_q <= byte_cnt_q + 61'd1;
						end
						if (fire_block) begin
							final_q    <= 1'b0;
							extra_q    <= 1'b0;
							end_pend_q <= message_end;
						end else if (message_end) begin
							pad_w_q     <= p_end[5:2];
							pad_first_q <= 1'b1;
							pad_lane_q  <= p_end[1:0];
							len_blk_q   <= (p_end < LEN_LIMIT);
						end
					end
				end
				ST_PAD: begin
					if (pad_w_q == LAST_WORD) begin
						final_q <= len_blk_q;
						extra_q <= !len_blk_q;
					end else begin
						pad_w_q <= pad_w_q + 4'd1;
					end
					pad_first_q <= 1'b0;
				end
				ST_ROUND: round_q <= round_q + 6'd1;
				ST_FOLD: begin
					if (final_q) begin
						if (!dvalid_q) begin
							chain_q    <= IV;
							fill_q     <= '0;
							byte_cnt_q <= '0;
							final_q    <= 1'b0;
							dvalid_q   <= 1'b1;
							idx_q      <= '0;
						end
					end else begin
						chain_q <= chain_sum;
						if (extra_q) begin
							pad_w_q     <= '0;
							pad_first_q <= 1'b0;
							len_blk_q   <= 1'b1;
							extra_q     <= 1'b0;
						end else if (end_pend_q) begin
							pad_w_q     <= '0;
							pad_first_q <= 1'b1;
							pad_lane_q  <= '0;
							len_blk_q   <= 1'b1;
							end_pend_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign digest_valid = dvalid_q;
	assign digest_word  = digest_q[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == LAST_INDEX);

endmodule
`default_nettype wire

/* design/md5_round.sv */
// One MD5 round step on the working registers.
`default_nettype none
module md5_round
	import md5_pkg::*;
(
	input  wire md5_work_t   work,
	input  wire logic [31:0] msg,
	input  wire logic [5:0]  rnd,
	output md5_work_t        work_next
);

	logic [31:0] f;
	logic [31:0] t;
	logic [63:0] rot;

	always_comb begin
		unique case (rnd[5:4])
			2'd0: f = (work.b & work.c) | (~work.b & work.d);
			2'd1: f = (work.b & work.d) | (work.c & ~work.d);
			2'd2: f = work.b ^ work.c ^ work.d;
			default: f = work.c ^ (work.b | ~work.d);
		endcase
		t = work.a + f + msg + ROUND_K[rnd];
		rot = {t, t} << rot_amt(rnd);
		work_next.a = work.d;
		work_next.b = work.b + rot[63:32];
		work_next.c = work.b;
		work_next.d = work.c;
	end

endmodule
`default_nettype wire

/* design/md5_checker.sv */
// Port-level checker for the MD5 engine digest channel, bound to the hash engine module.
`default_nettype none
`include "assert_macros.svh"
module md5_checker
	import md5_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        digest_valid,
	input wire logic        digest_ready,
	input wire logic [31:0] digest_word,
	input wire logic [1:0]  word_index,
	input wire logic        last_word
);

	`ASSERT_ALWAYS(a_last_flag, !digest_valid || (last_word == (word_index == LAST_INDEX)), "last_word mismatch")
	`ASSERT_ALWAYS(a_first_index, !$rose(digest_valid) || (word_index == 2'd0), "digest must start at word 0")
	`ASSERT_NEXT(a_word_order, digest_valid && digest_ready && !last_word, digest_valid && (word_index == $past(word_index) + 2'd1), "digest words out of order")
	`ASSERT_NEXT(a_hold, digest_valid && !digest_ready, digest_valid && $stable(digest_word) && $stable(word_index), "stalled digest transaction changed")

endmodule

bind md5_hash_engine md5_checker u_md5_checker (.*);
`default_nettype wire
